// ----- rtl/rfsp_pkg.sv -----
// rfsp_pkg: shared types, constants and status codes of the rf frame scene parser
// used by rfsp_step and rf_frame_scene_parser; depends on nothing

package rfsp_pkg;

    localparam int unsigned MAX_DATA = 32;

    localparam logic [7:0] SYNC_BYTE  = 8'hAA;
    localparam logic [7:0] SCENE_BASE = 8'hCA;
    localparam logic [7:0] HDR_LAST   = 8'd3;   // index of the length byte in the header

    localparam logic [5:0] EVENT_LIMIT_RST = 6'd16;

    typedef enum logic [1:0] {
        ST_SCENE = 2'd0,
        ST_FRAME = 2'd1,
        ST_CSUM  = 2'd2,
        ST_HDR   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] byte_count;
        logic       flag_ok;
        logic [7:0] command_byte;
        logic [7:0] length_byte;
        logic [7:0] running_sum;
        logic [7:0] first_data;
        logic [7:0] second_data;
    } t_parse_state;

    typedef struct packed {
        t_status    status;
        logic [5:0] scene_index;
        logic [5:0] scene_value;
        logic [7:0] frame_command;
    } t_result;

endpackage

// ----- rtl/rf_frame_scene_parser.sv -----
// rf_frame_scene_parser: sync/length/checksum frame parser with scene event decode
// depends on rfsp_pkg and rfsp_step
// a status is registered and appears on the master side in the cycle after the byte that causes it is taken
// throughput: one byte per cycle while s_axis_tready is high; the single result register is refilled while it drains
// s_axis_tready drops only while a status waits and m_axis_tready is low
// reset (synchronous, active low) returns to sync hunting, clears state and the output
// valid, and sets event_limit to 16

module rf_frame_scene_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,   // event_limit
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // scene_index[5:0], scene_value[11:6],
                                       // frame_command[19:12], zero fill[23:20]
    output logic [1:0]  m_axis_tuser   // status
);
    import rfsp_pkg::*;

    t_parse_state r_state;
    t_parse_state n_state;
    t_result      r_res;
    t_result      n_res;
    logic         r_res_valid;
    logic         n_res_valid;
    logic [5:0]   r_event_limit;
    logic         in_xfer;

    rfsp_step u_step (
        .i_state       (r_state),
        .i_byte        (s_axis_tdata),
        .i_event_limit (r_event_limit),
        .o_state       (n_state),
        .o_res_valid   (n_res_valid),
        .o_res         (n_res)
    );

    assign s_axis_tready = !r_res_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= '{phase: PH_HUNT, default: '0};
            r_res_valid   <= 1'b0;
            r_event_limit <= EVENT_LIMIT_RST;
        end else begin
            if (i_cfg_we) begin
                r_event_limit <= i_cfg_wdata;
            end
            if (in_xfer) begin
                r_state     <= n_state;
                r_res_valid <= n_res_valid;
            end else if (m_axis_tready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer && n_res_valid) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_res_valid;
    assign m_axis_tdata  = {4'b0000, r_res.frame_command, r_res.scene_value,
                            r_res.scene_index};
    assign m_axis_tuser  = r_res.status;

endmodule

// ----- rtl/rfsp_step.sv -----
// rfsp_step: next parser state and optional status for one received byte
// depends on rfsp_pkg

module rfsp_step (
    input  rfsp_pkg::t_parse_state i_state,
    input  logic [7:0]             i_byte,
    input  logic [5:0]             i_event_limit,
    output rfsp_pkg::t_parse_state o_state,
    output logic                   o_res_valid,
    output rfsp_pkg::t_result      o_res
);
    import rfsp_pkg::*;

    logic [7:0] sum_next;
    logic [7:0] idx_raw;
    logic [7:0] val_raw;
    logic       scene_ok;
    logic       len_bad;

    assign sum_next = i_state.running_sum + i_byte;
    assign idx_raw  = i_state.first_data - SCENE_BASE;
    assign val_raw  = i_state.second_data - SCENE_BASE;
    assign len_bad  = i_byte > 8'(MAX_DATA);

    // first byte must be in [base, base + limit), second only at least base
    assign scene_ok = (i_state.command_byte == 8'd1) && (i_state.length_byte == 8'd2)
                   && (i_state.first_data >= SCENE_BASE)
                   && (idx_raw < {2'b00, i_event_limit})
                   && (i_state.second_data >= SCENE_BASE);

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '{status: ST_FRAME, scene_index: 6'd0, scene_value: 6'd0,
                        frame_command: 8'd0};
        unique case (i_state.phase)
            PH_HEADER: begin
                o_state.running_sum = sum_next;
                o_state.byte_count  = i_state.byte_count + 8'd1;
                if (i_state.byte_count == 8'd1) begin
                    o_state.flag_ok = (i_byte == 8'd0) || (i_byte == 8'd1);
                end else if (i_state.byte_count == 8'd2) begin
                    o_state.command_byte = i_byte;
                end else if (i_state.byte_count >= HDR_LAST) begin
                    o_state.length_byte = i_byte;
                    if (!i_state.flag_ok || len_bad) begin
                        o_state.phase      = PH_HUNT;
                        o_state.byte_count = i_state.byte_count;
                        o_res_valid        = 1'b1;
                        o_res.status       = ST_HDR;
                    end else begin
                        o_state.phase      = PH_DATA;
                        o_state.byte_count = 8'd0;
                    end
                end
            end
            PH_DATA: begin
                if (i_state.byte_count < i_state.length_byte) begin
                    if (i_state.byte_count == 8'd0) begin
                        o_state.first_data = i_byte;
                    end else if (i_state.byte_count == 8'd1) begin
                        o_state.second_data = i_byte;
                    end
                    o_state.running_sum = sum_next;
                    o_state.byte_count  = i_state.byte_count + 8'd1;
                end else begin
                    // checksum byte closes the frame
                    o_state.phase       = PH_HUNT;
                    o_res_valid         = 1'b1;
                    o_res.frame_command = i_state.command_byte;
                    if (i_byte != i_state.running_sum) begin
                        o_res.status = ST_CSUM;
                    end else if (scene_ok) begin
                        o_res.status      = ST_SCENE;
                        o_res.scene_index = idx_raw[5:0];
                        o_res.scene_value = val_raw[5:0];
                    end else begin
                        o_res.status = ST_FRAME;
                    end
                end
            end
            default: begin
                o_state.phase = PH_HUNT;
                if (i_byte == SYNC_BYTE) begin
                    o_state.phase       = PH_HEADER;
                    o_state.byte_count  = 8'd0;
                    o_state.running_sum = 8'd0;
                    o_state.flag_ok     = 1'b0;
                end
            end
        endcase
    end

endmodule
